// ===== sv/ihif_pkg.sv =====
package ihif_pkg;

    // Fixed codes of the image layout
    localparam logic [31:0] BLOCK_MARK = 32'hffffded3;
    localparam logic [7:0]  TYPE_LAST  = 8'hff;
    localparam logic [7:0]  TYPE_HASH  = 8'h4b;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_MARKER = 3'd1;
    localparam logic [2:0] ST_ZERO_SIZE = 3'd2;
    localparam logic [2:0] ST_NO_HASH   = 3'd3;
    localparam logic [2:0] ST_BAD_LINK  = 3'd4;
    localparam logic [2:0] ST_EARLY_END = 3'd5;

    // Parser phase, one-hot
    typedef enum logic [5:0] {
        PH_SEARCH  = 6'b000001,
        PH_ITEM    = 6'b000010,
        PH_LINK    = 6'b000100,
        PH_CAPTURE = 6'b001000,
        PH_REPORT  = 6'b010000,
        PH_DONE    = 6'b100000
    } phase_t;

    // One result item
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        is_status;
        logic [2:0]  status;
    } result_t;

endpackage

// ===== sv/image_hash_item_finder.sv =====
// An accepted input item waits in the input register; its result item, if any, is
// captured in the result register and offered on the master side from there.
// Throughput: 1 input item per cycle while the result register is free; the parser
// state updates once per word in one pass between the input and result registers.
// Reset (rst_n low, asynchronous): parser returns to marker search at offset 0,
// both register stages are emptied.
module image_hash_item_finder
    import ihif_pkg::*;
#(
    parameter int SCAN_WORDS   = 1024,
    parameter int MAX_BLOCKS   = 4,
    parameter int MAX_ITEMS    = 32,
    parameter int DIGEST_WORDS = 8,
    parameter int OFFSET_BITS  = 22
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] image_word
    input  logic        s_tlast,   // image_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, [37:35] status
    output logic        m_tuser    // is_status
);

    logic        held_valid;
    logic [31:0] held_word;
    logic        held_last;
    logic        out_free;
    logic        step;
    logic        res_valid;
    result_t     res;
    result_t     out_res;

    assign step = held_valid && out_free;

    // Input register
    ihif_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_word    (s_tdata),
        .in_last    (s_tlast),
        .advance    (step),
        .held_valid (held_valid),
        .held_word  (held_word),
        .held_last  (held_last)
    );

    // Item chain walker
    ihif_walker #(
        .SCAN_WORDS   (SCAN_WORDS),
        .MAX_BLOCKS   (MAX_BLOCKS),
        .MAX_ITEMS    (MAX_ITEMS),
        .DIGEST_WORDS (DIGEST_WORDS),
        .OFFSET_BITS  (OFFSET_BITS)
    ) u_walker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .word      (held_word),
        .last      (held_last),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register
    ihif_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && res_valid),
        .res       (res),
        .free      (out_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {2'b00, out_res.status, out_res.word_index, out_res.digest_word};
    assign m_tuser = out_res.is_status;

endmodule

// ===== sv/ihif_in_stage.sv =====
module ihif_in_stage
    import ihif_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] in_word,
    input  logic        in_last,
    input  logic        advance,
    output logic        held_valid,
    output logic [31:0] held_word,
    output logic        held_last
);

    logic        valid_reg;
    logic [31:0] word_reg;
    logic        last_reg;

    // Slot frees when the held item moves on in the same cycle
    assign in_ready   = !valid_reg || advance;
    assign held_valid = valid_reg;
    assign held_word  = word_reg;
    assign held_last  = last_reg;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= in_word;
            last_reg <= in_last;
        end
    end

endmodule

// ===== sv/ihif_walker.sv =====
module ihif_walker
    import ihif_pkg::*;
#(
    parameter int SCAN_WORDS   = 1024,
    parameter int MAX_BLOCKS   = 4,
    parameter int MAX_ITEMS    = 32,
    parameter int DIGEST_WORDS = 8,
    parameter int OFFSET_BITS  = 22
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [31:0] word,
    input  logic        last,
    output logic        res_valid,
    output result_t     res
);

    localparam int OB = OFFSET_BITS;
    localparam int BC_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int IC_W = $clog2(MAX_ITEMS + 1);
    localparam int CC_W = $clog2(DIGEST_WORDS + 1);
    localparam logic [OB-1:0] OFFSET_LIMIT = {OB{1'b1}};
    localparam logic [OB-1:0] SCAN_END =
        (SCAN_WORDS > (2 ** OB) - 2) ? OB'((2 ** OB) - 2) : OB'(SCAN_WORDS);
    localparam logic [7:0]    HASH_MIN   = 8'(1 + DIGEST_WORDS);
    localparam logic [BC_W:0] BLOCK_LIM  = (BC_W + 1)'(MAX_BLOCKS);
    localparam logic [IC_W:0] ITEM_LIM   = (IC_W + 1)'(MAX_ITEMS);
    localparam logic [CC_W:0] DIGEST_LIM = (CC_W + 1)'(DIGEST_WORDS);

    phase_t        phase_reg, phase_next;
    logic [OB-1:0] offset_reg, offset_next;
    logic [OB-1:0] start_reg, start_next;
    logic [OB-1:0] target_reg, target_next;
    logic [BC_W-1:0] blocks_reg, blocks_next;
    logic [IC_W-1:0] items_reg, items_next;
    logic [CC_W-1:0] capt_reg, capt_next;

    logic [7:0]    item_type;
    logic [7:0]    item_size;
    logic [OB:0]   item_end;
    logic [30:0]   link_tgt;
    logic [IC_W:0] items_inc;
    logic [CC_W:0] capt_inc;
    logic [BC_W:0] blocks_inc;
    logic          emit;
    logic          is_st;
    logic [2:0]    st;

    assign item_type  = word[7:0];
    assign item_size  = word[15:8];
    assign item_end   = {1'b0, offset_reg} + (OB + 1)'(item_size);
    assign link_tgt   = 31'(start_reg) + {1'b0, word[31:2]};
    assign items_inc  = {1'b0, items_reg} + 1'b1;
    assign capt_inc   = {1'b0, capt_reg} + 1'b1;
    assign blocks_inc = {1'b0, blocks_reg} + 1'b1;

    // Per-word decision
    always_comb
    begin
        phase_next  = phase_reg;
        start_next  = start_reg;
        target_next = target_reg;
        blocks_next = blocks_reg;
        items_next  = items_reg;
        capt_next   = capt_reg;
        emit        = 1'b0;
        is_st       = 1'b0;
        st          = ST_OK;
        res         = '0;

        case (phase_reg)
            PH_SEARCH:
            begin
                if (word == BLOCK_MARK && offset_reg < SCAN_END)
                begin
                    start_next  = offset_reg;
                    target_next = offset_reg + 1'b1;
                    items_next  = '0;
                    blocks_next = '0;
                    phase_next  = PH_ITEM;
                end
                else if ({1'b0, offset_reg} + 1'b1 >= {1'b0, SCAN_END})
                begin
                    emit = 1'b1; is_st = 1'b1; st = ST_NO_MARKER;
                end
            end
            PH_ITEM:
            begin
                if (offset_reg == target_reg)
                begin
                    if (item_type == TYPE_LAST)
                    begin
                        phase_next = PH_LINK;
                    end
                    else if (item_type == TYPE_HASH && item_size >= HASH_MIN)
                    begin
                        capt_next  = '0;
                        phase_next = PH_CAPTURE;
                    end
                    else if (item_size == 8'd0)
                    begin
                        emit = 1'b1; is_st = 1'b1; st = ST_ZERO_SIZE;
                    end
                    else if (item_end >= {1'b0, OFFSET_LIMIT})
                    begin
                        emit = 1'b1; is_st = 1'b1; st = ST_BAD_LINK;
                    end
                    else
                    begin
                        target_next = item_end[OB-1:0];
                        items_next  = items_inc[IC_W-1:0];
                        if (items_inc >= ITEM_LIM)
                        begin
                            emit = 1'b1; is_st = 1'b1; st = ST_NO_HASH;
                        end
                    end
                end
            end
            PH_LINK:
            begin
                if (word == 32'd0 || blocks_inc >= BLOCK_LIM)
                begin
                    emit = 1'b1; is_st = 1'b1; st = ST_NO_HASH;
                end
                else if (word[1:0] != 2'b00)
                begin
                    emit = 1'b1; is_st = 1'b1; st = ST_BAD_LINK;
                end
                else if (link_tgt < 31'(offset_reg) || link_tgt >= 31'(OFFSET_LIMIT - 1'b1))
                begin
                    emit = 1'b1; is_st = 1'b1; st = ST_BAD_LINK;
                end
                else
                begin
                    blocks_next = blocks_inc[BC_W-1:0];
                    start_next  = link_tgt[OB-1:0];
                    target_next = link_tgt[OB-1:0] + 1'b1;
                    items_next  = '0;
                    phase_next  = PH_ITEM;
                end
            end
            PH_CAPTURE:
            begin
                emit            = 1'b1;
                res.digest_word = word;
                res.word_index  = 3'(capt_reg);
                capt_next       = capt_inc[CC_W-1:0];
                if (capt_inc >= DIGEST_LIM)
                begin
                    phase_next = PH_REPORT;
                end
            end
            PH_REPORT:
            begin
                emit = 1'b1; is_st = 1'b1; st = ST_OK;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        if (is_st)
        begin
            phase_next = PH_DONE;
        end
        offset_next = (offset_reg < OFFSET_LIMIT) ? offset_reg + 1'b1 : offset_reg;

        // End of image: flag an unfinished block, then re-arm
        if (last)
        begin
            if (!is_st && phase_reg != PH_DONE)
            begin
                emit            = 1'b1;
                is_st           = 1'b1;
                st              = ST_EARLY_END;
                res.digest_word = '0;
                res.word_index  = '0;
            end
            phase_next  = PH_SEARCH;
            offset_next = '0;
            start_next  = '0;
            target_next = '0;
            blocks_next = '0;
            items_next  = '0;
            capt_next   = '0;
        end

        res.is_status = is_st;
        res.status    = st;
    end

    assign res_valid = emit;

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SEARCH;
            offset_reg <= '0;
            start_reg  <= '0;
            target_reg <= '0;
            blocks_reg <= '0;
            items_reg  <= '0;
            capt_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            start_reg  <= start_next;
            target_reg <= target_next;
            blocks_reg <= blocks_next;
            items_reg  <= items_next;
            capt_reg   <= capt_next;
        end
    end

endmodule

// ===== sv/ihif_out_stage.sv =====
module ihif_out_stage
    import ihif_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res,
    output logic    free,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    valid_reg;
    result_t res_reg;

    // Room for a new item when empty or being drained
    assign free      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

// ===== bench/ihif_result_checker.sv =====
module ihif_result_checker
    import ihif_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] image_word
    input  logic        s_tlast,   // image_end
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, [37:35] status
    input  logic        m_tuser,   // is_status
    output int          mismatch_count,
    output int          results_owed
);

    // Same settings as the block's defaults
    localparam int SCAN_WORDS   = 1024;
    localparam int MAX_BLOCKS   = 4;
    localparam int MAX_ITEMS    = 32;
    localparam int DIGEST_WORDS = 8;
    localparam int OFFSET_BITS  = 22;
    localparam int OFFSET_LIMIT = (1 << OFFSET_BITS) - 1;

    // Walker state, mirrors the parser
    phase_t      walk_phase;
    logic [21:0] cur_off;
    logic [21:0] blk_start;
    logic [21:0] hdr_off;
    logic [2:0]  links_taken;
    logic [5:0]  items_seen;
    logic [3:0]  digest_cnt;

    result_t expected_results[$];

    task automatic restart_walk();
        walk_phase  = PH_SEARCH;
        cur_off     = '0;
        blk_start   = '0;
        hdr_off     = '0;
        links_taken = '0;
        items_seen  = '0;
        digest_cnt  = '0;
    endtask

    // Advance the walker by one image word; queue the result it owes, if any
    task automatic parse_word(input logic [31:0] w, input logic eoi);
        phase_t      entry_phase;
        logic        emit;
        logic        st_flag;
        logic [2:0]  st;
        logic [31:0] dw;
        logic [2:0]  idx;
        logic [7:0]  kind;
        logic [7:0]  len;
        logic [63:0] tgt;
        int          scan_end;
        result_t     r;
        entry_phase = walk_phase;
        emit        = 1'b0;
        st_flag     = 1'b0;
        st          = ST_OK;
        dw          = '0;
        idx         = '0;
        kind        = w[7:0];
        len         = w[15:8];
        scan_end    = (SCAN_WORDS > OFFSET_LIMIT - 1) ? OFFSET_LIMIT - 1 : SCAN_WORDS;

        case (walk_phase)
            PH_SEARCH:
            begin
                if (w == BLOCK_MARK && cur_off < scan_end)
                begin
                    blk_start   = cur_off;
                    hdr_off     = cur_off + 1'b1;
                    items_seen  = '0;
                    links_taken = '0;
                    walk_phase  = PH_ITEM;
                end
                else if (cur_off + 1 >= scan_end)
                begin
                    emit = 1'b1; st_flag = 1'b1; st = ST_NO_MARKER;
                end
            end
            PH_ITEM:
            begin
                if (cur_off == hdr_off)
                begin
                    if (kind == TYPE_LAST)
                        walk_phase = PH_LINK;
                    else if (kind == TYPE_HASH && len >= 1 + DIGEST_WORDS)
                    begin
                        digest_cnt = '0;
                        walk_phase = PH_CAPTURE;
                    end
                    else if (len == 0)
                    begin
                        emit = 1'b1; st_flag = 1'b1; st = ST_ZERO_SIZE;
                    end
                    else
                    begin
                        tgt = 64'(cur_off) + 64'(len);
                        if (tgt >= OFFSET_LIMIT)
                        begin
                            emit = 1'b1; st_flag = 1'b1; st = ST_BAD_LINK;
                        end
                        else
                        begin
                            hdr_off    = tgt[21:0];
                            items_seen = items_seen + 1'b1;
                            if (items_seen >= MAX_ITEMS)
                            begin
                                emit = 1'b1; st_flag = 1'b1; st = ST_NO_HASH;
                            end
                        end
                    end
                end
            end
            PH_LINK:
            begin
                // block budget is checked before the link itself
                if (w == 0 || links_taken + 1 >= MAX_BLOCKS)
                begin
                    emit = 1'b1; st_flag = 1'b1; st = ST_NO_HASH;
                end
                else if (w[1:0] != 2'b00)
                begin
                    emit = 1'b1; st_flag = 1'b1; st = ST_BAD_LINK;
                end
                else
                begin
                    tgt = 64'(blk_start) + 64'(w[31:2]);
                    if (tgt < cur_off || tgt + 1 >= OFFSET_LIMIT)
                    begin
                        emit = 1'b1; st_flag = 1'b1; st = ST_BAD_LINK;
                    end
                    else
                    begin
                        links_taken = links_taken + 1'b1;
                        blk_start   = tgt[21:0];
                        hdr_off     = tgt[21:0] + 1'b1;
                        items_seen  = '0;
                        walk_phase  = PH_ITEM;
                    end
                end
            end
            PH_CAPTURE:
            begin
                emit       = 1'b1;
                dw         = w;
                idx        = digest_cnt[2:0];
                digest_cnt = digest_cnt + 1'b1;
                if (digest_cnt >= DIGEST_WORDS)
                    walk_phase = PH_REPORT;
            end
            PH_REPORT:
            begin
                emit = 1'b1; st_flag = 1'b1; st = ST_OK;
            end
            default:
                walk_phase = PH_DONE;
        endcase

        if (st_flag)
            walk_phase = PH_DONE;
        if (cur_off < OFFSET_LIMIT)
            cur_off = cur_off + 1'b1;

        // image end: anything still open turns into an early-end status
        if (eoi)
        begin
            if (!st_flag && entry_phase != PH_DONE)
            begin
                emit = 1'b1; st_flag = 1'b1; st = ST_EARLY_END; dw = '0; idx = '0;
            end
            restart_walk();
        end

        if (emit)
        begin
            r.digest_word = dw;
            r.word_index  = idx;
            r.is_status   = st_flag;
            r.status      = st;
            expected_results.push_back(r);
        end
    endtask

    task automatic flag_mismatch(input string what, input result_t want, input result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t %s: want dw=%h idx=%0d is_st=%0b st=%0d, %s dw=%h idx=%0d is_st=%0b st=%0d",
                     $realtime, what, want.digest_word, want.word_index, want.is_status,
                     want.status, "got", got.digest_word, got.word_index, got.is_status,
                     got.status);
    endtask

    // Score result items, then predict from input items
    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            restart_walk();
            expected_results.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.digest_word = m_tdata[31:0];
                got.word_index  = m_tdata[34:32];
                got.status      = m_tdata[37:35];
                got.is_status   = m_tuser;
                if (expected_results.size() == 0)
                begin
                    want = '0;
                    flag_mismatch("unexpected result", want, got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.digest_word !== want.digest_word ||
                        got.word_index !== want.word_index ||
                        got.is_status !== want.is_status || got.status !== want.status)
                        flag_mismatch("result mismatch", want, got);
                end
            end
            if (s_tvalid && s_tready)
                parse_word(s_tdata, s_tlast);
        end
        results_owed = expected_results.size();
    end

endmodule

// ===== bench/tb_image_hash_item_finder.sv =====
module tb_image_hash_item_finder;
    import ihif_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_WORDS = 650;
    localparam int LONG_HOLD    = 300;
    localparam int DIGEST_WORDS_BOUND = 9;
    localparam int MAX_LINKS = 3;

    // How a random image gets broken
    typedef enum int {
        DAMAGE_NONE,
        DAMAGE_ZERO_SIZE,
        DAMAGE_MANY_ITEMS,
        DAMAGE_ZERO_LINK,
        DAMAGE_MANY_BLOCKS,
        DAMAGE_ODD_LINK,
        DAMAGE_BACK_LINK,
        DAMAGE_FAR_LINK,
        DAMAGE_EARLY_END,
        DAMAGE_NOISE
    } damage_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] image_word
    logic        s_tlast;   // image_end
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [31:0] digest_word, [34:32] word_index, [37:35] status
    logic        m_tuser;   // is_status

    int mismatch_count;
    int results_owed;

    logic [31:0] image_q[$];
    int          blk_base;
    int          words_fed;
    int          quiet_cycles;
    int          stall_left;
    bit          feed_gaps;
    bit          drain_gaps;
    bit          hold_request;

    image_hash_item_finder DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    ihif_result_checker scoreboard (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        m_tready   = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready    <= 1'b0;
                stall_left   = LONG_HOLD - 1;
            end
            else if (drain_gaps && $urandom_range(0, 6) == 0)
            begin
                m_tready  <= 1'b0;
                stall_left = $urandom_range(1, 10) - 1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog: no item moving on either side for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[image_hash_item_finder] ERROR");
            $finish;
        end
    end

    task automatic feed_word(input logic [31:0] w, input logic eoi);
        @(negedge clk);
        if (feed_gaps && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tlast  <= eoi;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        words_fed++;
    endtask

    task automatic feed_image();
        int i;
        for (i = 0; i < image_q.size(); i++)
            feed_word(image_q[i], i == image_q.size() - 1);
    endtask

    function automatic logic [31:0] not_marker();
        logic [31:0] w;
        w = $urandom();
        if (w == BLOCK_MARK)
            w = w ^ 32'h1;
        return w;
    endfunction

    function automatic logic [31:0] header(input logic [7:0] kind, input logic [7:0] len);
        logic [31:0] r;
        r = $urandom();
        return {r[31:16], len, kind};
    endfunction

    // Ordinary item, sometimes a hash item too short to count
    task automatic add_item();
        logic [7:0] kind;
        logic [7:0] len;
        kind = 8'($urandom_range(0, 254));
        len  = 8'($urandom_range(1, 4));
        if ($urandom_range(0, 5) == 0)
        begin
            kind = TYPE_HASH;
            len  = 8'($urandom_range(1, DIGEST_WORDS_BOUND - 1));
        end
        else if ($urandom_range(0, 9) == 0 && kind != TYPE_HASH)
            len = 8'($urandom_range(5, 40));
        image_q.push_back(header(kind, len));
        repeat (len - 1) image_q.push_back($urandom());
    endtask

    // Last item, a forward link, and the gap up to the next block
    task automatic add_link();
        int link_at;
        int tgt;
        image_q.push_back(header(TYPE_LAST, 8'($urandom_range(0, 255))));
        link_at = image_q.size();
        tgt     = link_at + $urandom_range(0, 3);
        image_q.push_back(32'((tgt - blk_base) << 2));
        while (image_q.size() < tgt + 1)
            image_q.push_back($urandom());
        blk_base = tgt;
    endtask

    task automatic build_image(input damage_t damage, input int lead);
        int       nlinks;
        int       b;
        int       nitems;
        int       keep;
        int       link_at;
        logic [31:0] r;
        image_q.delete();

        // pure noise, now and then with a marker in it
        if (damage == DAMAGE_NOISE)
        begin
            repeat ($urandom_range(1, 24))
                image_q.push_back(($urandom_range(0, 5) == 0) ? BLOCK_MARK : $urandom());
            return;
        end

        repeat (lead) image_q.push_back(not_marker());
        blk_base = image_q.size();
        image_q.push_back(BLOCK_MARK);

        nlinks = (damage == DAMAGE_MANY_BLOCKS) ? MAX_LINKS : $urandom_range(0, MAX_LINKS - 1);
        for (b = 0; b <= nlinks; b++)
        begin
            nitems = (damage == DAMAGE_MANY_ITEMS && b == nlinks) ? 32 : $urandom_range(0, 4);
            repeat (nitems) add_item();
            if (b < nlinks)
                add_link();
        end

        // how the last block ends
        case (damage)
            DAMAGE_ZERO_SIZE:
                image_q.push_back(header(8'($urandom_range(0, 254)), 8'd0));
            DAMAGE_MANY_ITEMS:
                ;
            DAMAGE_ZERO_LINK:
            begin
                image_q.push_back(header(TYPE_LAST, 8'($urandom_range(0, 255))));
                image_q.push_back(32'h0);
            end
            DAMAGE_MANY_BLOCKS:
                add_link();
            DAMAGE_ODD_LINK:
            begin
                image_q.push_back(header(TYPE_LAST, 8'($urandom_range(0, 255))));
                link_at = image_q.size();
                image_q.push_back(32'(((link_at + $urandom_range(0, 3) - blk_base) << 2)
                                      | $urandom_range(1, 3)));
            end
            DAMAGE_BACK_LINK:
            begin
                image_q.push_back(header(TYPE_LAST, 8'($urandom_range(0, 255))));
                link_at = image_q.size();
                image_q.push_back(32'($urandom_range(1, link_at - blk_base - 1) << 2));
            end
            DAMAGE_FAR_LINK:
            begin
                image_q.push_back(header(TYPE_LAST, 8'($urandom_range(0, 255))));
                r = $urandom();
                image_q.push_back({1'b1, r[28:0], 2'b00});
            end
            default:
            begin
                image_q.push_back(header(TYPE_HASH, 8'($urandom_range(9, 12))));
                repeat (8) image_q.push_back($urandom());
                image_q.push_back($urandom());
            end
        endcase
        repeat ($urandom_range(0, 3)) image_q.push_back($urandom());

        // cut short, mostly near the digest and status words
        if (damage == DAMAGE_EARLY_END)
        begin
            if ($urandom_range(0, 2) == 0)
                keep = $urandom_range(1, image_q.size());
            else
            begin
                keep = image_q.size() - $urandom_range(1, 12);
                if (keep < 1)
                    keep = 1;
            end
            while (image_q.size() > keep)
                void'(image_q.pop_back());
        end
    endtask

    function automatic damage_t pick_damage();
        int p;
        p = $urandom_range(0, 99);
        if (p < 35)      return DAMAGE_NONE;
        else if (p < 50) return DAMAGE_EARLY_END;
        else if (p < 57) return DAMAGE_ZERO_SIZE;
        else if (p < 63) return DAMAGE_MANY_ITEMS;
        else if (p < 69) return DAMAGE_ZERO_LINK;
        else if (p < 75) return DAMAGE_MANY_BLOCKS;
        else if (p < 81) return DAMAGE_ODD_LINK;
        else if (p < 87) return DAMAGE_BACK_LINK;
        else if (p < 92) return DAMAGE_FAR_LINK;
        else             return DAMAGE_NOISE;
    endfunction

    // Stimulus and verdict
    initial
    begin : stimulus
        int start_words;
        int images;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        feed_gaps    = 1'b0;
        drain_gaps   = 1'b0;
        hold_request = 1'b0;
        words_fed    = 0;
        quiet_cycles = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // lone final word
        feed_word(32'h0000_0000, 1'b1);
        // clean hash right after the marker, extreme digest values
        feed_word(32'hffff_ffff, 1'b0);
        feed_word(BLOCK_MARK, 1'b0);
        feed_word({16'hffff, 8'd9, TYPE_HASH}, 1'b0);
        feed_word(32'h0000_0000, 1'b0);
        feed_word(32'hffff_ffff, 1'b0);
        feed_word(32'ha5a5_a5a5, 1'b0);
        feed_word(32'h5a5a_5a5a, 1'b0);
        feed_word(32'h0000_0001, 1'b0);
        feed_word(32'h8000_0000, 1'b0);
        feed_word(32'h1234_5678, 1'b0);
        feed_word(32'hfedc_ba98, 1'b0);
        feed_word(32'h0000_0000, 1'b0);
        feed_word(32'hffff_ffff, 1'b1);
        // zero-size item on the final word keeps its status
        feed_word(BLOCK_MARK, 1'b0);
        feed_word({16'h0000, 8'd0, 8'h01}, 1'b1);
        // last item with a zero link
        feed_word(BLOCK_MARK, 1'b0);
        feed_word({16'h0000, 8'd0, TYPE_LAST}, 1'b0);
        feed_word(32'h0000_0000, 1'b0);
        feed_word(32'h0000_0000, 1'b1);
        // image ends in the middle of the digest
        feed_word(BLOCK_MARK, 1'b0);
        feed_word({16'h0000, 8'd9, TYPE_HASH}, 1'b0);
        feed_word(32'hdead_beef, 1'b0);
        feed_word(32'hcafe_f00d, 1'b1);

        // marker never seen in the scan window
        feed_gaps  = 1'b1;
        drain_gaps = 1'b1;
        build_image(DAMAGE_NONE, 1024);
        feed_image();

        start_words = words_fed;
        images      = 0;
        while (words_fed - start_words < RANDOM_WORDS)
        begin
            if (words_fed - start_words > RANDOM_WORDS - 250)
            begin
                feed_gaps  = 1'b0;
                drain_gaps = 1'b0;
            end
            else
            begin
                feed_gaps  = ($urandom_range(0, 3) != 0);
                drain_gaps = ($urandom_range(0, 3) != 0);
            end
            if (images == 3)
                hold_request = 1'b1;
            build_image(pick_damage(), $urandom_range(0, 3));
            feed_image();
            images++;
        end

        @(negedge clk);
        s_tvalid <= 1'b0;

        while (results_owed != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatch_count == 0 && results_owed == 0)
            $display("[image_hash_item_finder] OK");
        else
            $display("[image_hash_item_finder] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ihif_pkg.sv
sv/ihif_in_stage.sv
sv/ihif_walker.sv
sv/ihif_out_stage.sv
sv/image_hash_item_finder.sv
bench/ihif_result_checker.sv
bench/tb_image_hash_item_finder.sv
